FILE: rtl/agpc_pkg.sv
// shared types and constants for the audio input gain and peak conditioner
package agpc_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned DemodW  = 12;
  localparam int unsigned OpW     = 18;
  localparam int unsigned ProdW   = 2 * OpW;

  localparam logic [SampleW-1:0] DiscardReset = 16'd8000;
  localparam logic signed [OpW-1:0] KnobCoef  = 18'sd4095;
  localparam logic signed [OpW-1:0] PeakCoef  = 18'sd32767;
  localparam logic signed [OpW-1:0] MidScale  = 18'sd32768;
  localparam logic [10:0] GainBase            = 11'd128;
  localparam logic [DemodW-1:0] DemodOffset   = 12'd2048;
  localparam logic [SampleW-1:0] EchoBase     = 16'd32767;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KNOB,
    ST_GAIN,
    ST_SAMP,
    ST_PEAK,
    ST_DONE
  } agpc_state_e;

  typedef struct packed {
    agpc_state_e state;
    logic        in_ready;
    logic        mac_en;
    logic        finish;
  } agpc_ctrl_t;

endpackage

FILE: rtl/agpc_in_if.sv
// request channel carrying one converter sample and one knob reading
interface agpc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_sample;
  logic [15:0] knob_level;

  modport source (output valid, output raw_sample, output knob_level, input ready);
  modport sink   (input valid, input raw_sample, input knob_level, output ready);
endinterface

FILE: rtl/agpc_out_if.sv
// result channel carrying echo, demodulator sample and peak
interface agpc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] echo_sample;
  logic [11:0] demod_sample;
  logic        demod_valid;
  logic [15:0] peak_level;

  modport source (output valid, output echo_sample, output demod_sample,
                  output demod_valid, output peak_level, input ready);
  modport sink   (input valid, input echo_sample, input demod_sample,
                  input demod_valid, input peak_level, output ready);
endinterface

FILE: rtl/agpc_mac.sv
// shared signed multiply-add unit with registered result
module agpc_mac (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [agpc_pkg::OpW-1:0]       a_i,
  input  logic signed [agpc_pkg::OpW-1:0]       b_i,
  input  logic signed [agpc_pkg::OpW-1:0]       c_i,
  output logic signed [agpc_pkg::ProdW-1:0]     p_o
);

  logic signed [agpc_pkg::ProdW-1:0] p_d;
  logic signed [agpc_pkg::ProdW-1:0] p_q;

  assign p_d = (agpc_pkg::ProdW)'(a_i * b_i)
             + {{(agpc_pkg::ProdW - agpc_pkg::OpW){c_i[agpc_pkg::OpW-1]}}, c_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

FILE: rtl/agpc_ctrl.sv
// sequencer stepping the shared multiply-add through one request
module agpc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_free_i,
  output agpc_pkg::agpc_ctrl_t ctrl_o
);

  agpc_pkg::agpc_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      agpc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = agpc_pkg::ST_KNOB;
      end
      agpc_pkg::ST_KNOB: state_d = agpc_pkg::ST_GAIN;
      agpc_pkg::ST_GAIN: state_d = agpc_pkg::ST_SAMP;
      agpc_pkg::ST_SAMP: state_d = agpc_pkg::ST_PEAK;
      agpc_pkg::ST_PEAK: state_d = agpc_pkg::ST_DONE;
      agpc_pkg::ST_DONE: begin
        if (out_free_i) begin
          state_d = in_valid_i ? agpc_pkg::ST_KNOB : agpc_pkg::ST_IDLE;
        end
      end
      default: state_d = agpc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o.state    = state_q;
    ctrl_o.in_ready = 1'b0;
    ctrl_o.mac_en   = 1'b0;
    ctrl_o.finish   = 1'b0;
    case (state_q)
      agpc_pkg::ST_IDLE: ctrl_o.in_ready = 1'b1;
      agpc_pkg::ST_KNOB,
      agpc_pkg::ST_GAIN,
      agpc_pkg::ST_SAMP,
      agpc_pkg::ST_PEAK: ctrl_o.mac_en = 1'b1;
      agpc_pkg::ST_DONE: begin
        // retire and take the next request in the same cycle
        ctrl_o.in_ready = out_free_i;
        ctrl_o.finish   = out_free_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= agpc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/audio_input_gain_peak_conditioner.sv
// top level: knob smoothing, squared-law gain, saturation, peak tracking and echo and demodulator outputs
// Each request is one converter sample and one gain-knob reading and yields one result.
// A request makes four passes through the single 18x18 multiply-add unit
// (knob filter, gain square, sample gain, peak decay) and then a retire step that moves the
// result into the output register, where the next request is accepted as well. The
// result waits in that register until taken, so a stalled sink holds the block only
// at the retire step. Writing cfg_wdata_i with cfg_we_i also restarts the discard period; until
// that many results have gone out, demod_valid stays low.
module audio_input_gain_peak_conditioner (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  agpc_in_if.sink           in_i,
  agpc_out_if.source        out_o
);

  localparam int unsigned OpW   = agpc_pkg::OpW;
  localparam int unsigned ProdW = agpc_pkg::ProdW;

  agpc_pkg::agpc_ctrl_t ctrl;

  logic out_valid_q;
  logic out_free;

  logic [15:0] raw_q, knob_q;
  logic [15:0] sk_q, sk_d;
  logic [15:0] peak_q, peak_d;
  logic [15:0] discard_left_q, discard_left_d;
  logic [15:0] s_q;
  logic [15:0] rect_q;

  logic signed [OpW-1:0]   mac_a, mac_b, mac_c;
  logic signed [ProdW-1:0] mac_p;

  logic [10:0]        gain;
  logic signed [27:0] s_full;
  logic [15:0]        s_sat;
  logic [16:0]        s_neg;
  logic [15:0]        rect;
  logic               left_zero;

  logic [15:0] echo_q;
  logic [11:0] demod_q;
  logic        dvalid_q;
  logic [15:0] peak_out_q;

  assign out_free = !out_valid_q || out_o.ready;

  agpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  agpc_mac u_mac (
    .clk_i (clk_i),
    .en_i  (ctrl.mac_en),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .c_i   (mac_c),
    .p_o   (mac_p)
  );

  assign in_i.ready = ctrl.in_ready;

  // results of the previous multiply-add pass
  assign sk_d   = mac_p[27:12];
  assign gain   = mac_p[31:21] + agpc_pkg::GainBase;
  assign s_full = mac_p[35:8];

  always_comb begin
    if (s_full > 28'sd32767) begin
      s_sat = 16'h7fff;
    end else if (s_full < -28'sd32768) begin
      s_sat = 16'h8000;
    end else begin
      s_sat = s_full[15:0];
    end
  end

  assign s_neg = 17'd0 - {s_sat[15], s_sat};
  assign rect  = s_sat[15] ? s_neg[15:0] : s_sat;

  always_comb begin
    mac_a = '0;
    mac_b = '0;
    mac_c = '0;
    case (ctrl.state)
      agpc_pkg::ST_KNOB: begin
        mac_a = {2'b00, sk_q};
        mac_b = agpc_pkg::KnobCoef;
        mac_c = {2'b00, knob_q};
      end
      agpc_pkg::ST_GAIN: begin
        mac_a = {2'b00, sk_d};
        mac_b = {3'b000, sk_d[15:1]};
      end
      agpc_pkg::ST_SAMP: begin
        mac_a = agpc_pkg::MidScale - {2'b00, raw_q};
        mac_b = {7'b0, gain};
      end
      agpc_pkg::ST_PEAK: begin
        mac_a = {2'b00, peak_q};
        mac_b = agpc_pkg::PeakCoef;
        mac_c = {2'b00, rect};
      end
      default: ;
    endcase
  end

  // instant attack, otherwise slow decay from the last pass
  assign peak_d    = (rect_q > peak_q) ? rect_q : mac_p[30:15];
  assign left_zero = (discard_left_q == 16'd0);

  always_comb begin
    discard_left_d = discard_left_q;
    if (cfg_we_i) begin
      discard_left_d = cfg_wdata_i;
    end else if (ctrl.finish && !left_zero) begin
      discard_left_d = discard_left_q - 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sk_q            <= '0;
      peak_q          <= '0;
      discard_left_q  <= agpc_pkg::DiscardReset;
      out_valid_q     <= 1'b0;
    end else begin
      if (ctrl.state == agpc_pkg::ST_GAIN) sk_q <= sk_d;
      if (ctrl.finish) peak_q <= peak_d;
      discard_left_q <= discard_left_d;
      if (ctrl.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && ctrl.in_ready) begin
      raw_q  <= in_i.raw_sample;
      knob_q <= in_i.knob_level;
    end
    if (ctrl.state == agpc_pkg::ST_PEAK) begin
      s_q    <= s_sat;
      rect_q <= rect;
    end
    if (ctrl.finish) begin
      echo_q     <= agpc_pkg::EchoBase - s_q;
      demod_q    <= agpc_pkg::DemodOffset + {{2{s_q[15]}}, s_q[15:6]};
      dvalid_q   <= left_zero;
      peak_out_q <= peak_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.echo_sample  = echo_q;
  assign out_o.demod_sample = demod_q;
  assign out_o.demod_valid  = dvalid_q;
  assign out_o.peak_level   = peak_out_q;

endmodule
